// ===== sv/amsm_pkg.sv =====
package amsm_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned STICK_W = 16;
    localparam int unsigned YAW_T_W = 15;
    localparam int unsigned DEB_W   = 16;
    localparam int unsigned PULSE_W = 12;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned CHG_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 8;

    // action codes
    localparam logic [ACT_W-1:0] ACT_STICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SWITCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MODE   = 2'd2;

    // arm change codes
    localparam logic [CHG_W-1:0] CHG_NONE     = 2'd0;
    localparam logic [CHG_W-1:0] CHG_ARMED    = 2'd1;
    localparam logic [CHG_W-1:0] CHG_DISARMED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THR_MAX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SW_ARM     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SW_DISARM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_SPLIT = 3'd5;

    typedef struct packed {
        logic signed [STICK_W-1:0] throttle_ceiling;
        logic [YAW_T_W-1:0]        yaw_trip;
        logic [DEB_W-1:0]          settle_ms;
        logic [PULSE_W-1:0]        switch_arm_us;
        logic [PULSE_W-1:0]        switch_disarm_us;
        logic [PULSE_W-1:0]        mode_split_us;
    } amsm_cfg_t;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic [TIME_W-1:0]         now_ms;
        logic signed [STICK_W-1:0] throttle;
        logic signed [STICK_W-1:0] yaw;
        logic [PULSE_W-1:0]        pulse_us;
    } amsm_item_t;

    typedef struct packed {
        logic             is_armed;
        logic             angle_mode;
        logic [CHG_W-1:0] arm_change;
        logic             mode_changed;
    } amsm_result_t;

endpackage

// ===== sv/arm_and_mode_state_machine.sv =====
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------------------
// s_       | in        | s_tvalid/s_tready  | tdata: now_ms, throttle, yaw, pulse_us
//          |           |                    | tuser: action
// m_       | out       | m_tvalid/m_tready  | tdata: is_armed, angle_mode, arm_change,
//          |           |                    |        mode_changed
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (write only)
//
// one word a cycle while the m_ side is not stalled; m_tvalid follows the s_ accept through the input
// register, then the result register written together with the flag/timer state.
// aresetn (synchronous) restores register defaults, disarmed, acro and zero timers.
// a stalled m_ side holds its word; the input register still takes one more word,
// and s_tready drops only when both registers are full.
// configuration writes are always accepted.
module arm_and_mode_state_machine (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // now_ms[31:0], throttle[47:32], yaw[63:48], pulse_us[75:64], zero[79:76]
    input  logic [amsm_pkg::IN_DATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [amsm_pkg::ACT_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // is_armed[0], angle_mode[1], arm_change[3:2], mode_changed[4], zero[7:5]
    output logic [amsm_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [amsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [amsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import amsm_pkg::*;

    amsm_cfg_t    cfg;
    amsm_item_t   item_reg;
    amsm_result_t result;
    amsm_result_t result_reg;
    logic         in_valid_reg;
    logic         out_valid_reg;
    logic         out_free;
    logic         fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    amsm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    amsm_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.action   <= s_tuser;
            item_reg.now_ms   <= s_tdata[31:0];
            item_reg.throttle <= $signed(s_tdata[47:32]);
            item_reg.yaw      <= $signed(s_tdata[63:48]);
            item_reg.pulse_us <= s_tdata[75:64];
        end
        if (fire) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, result_reg.mode_changed, result_reg.arm_change,
                       result_reg.angle_mode, result_reg.is_armed};

endmodule

// ===== sv/amsm_cfg.sv =====
module amsm_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [amsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [amsm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output amsm_pkg::amsm_cfg_t               cfg
);
    import amsm_pkg::*;

    amsm_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.throttle_ceiling <= 16'sd1638;
            cfg_reg.yaw_trip         <= 15'd14746;
            cfg_reg.settle_ms        <= 16'd250;
            cfg_reg.switch_arm_us    <= 12'd1700;
            cfg_reg.switch_disarm_us <= 12'd1300;
            cfg_reg.mode_split_us    <= 12'd1500;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_THR_MAX:    cfg_reg.throttle_ceiling <= $signed(cfg_data);
                REG_YAW_THR:    cfg_reg.yaw_trip         <= cfg_data[YAW_T_W-1:0];
                REG_DEBOUNCE:   cfg_reg.settle_ms        <= cfg_data[DEB_W-1:0];
                REG_SW_ARM:     cfg_reg.switch_arm_us    <= cfg_data[PULSE_W-1:0];
                REG_SW_DISARM:  cfg_reg.switch_disarm_us <= cfg_data[PULSE_W-1:0];
                REG_MODE_SPLIT: cfg_reg.mode_split_us    <= cfg_data[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/amsm_step.sv =====
module amsm_step (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   fire,
    input  amsm_pkg::amsm_item_t   item,
    input  amsm_pkg::amsm_cfg_t    cfg,
    output amsm_pkg::amsm_result_t result
);
    import amsm_pkg::*;

    logic              armed_reg, armed_next;
    logic              mode_reg, mode_next;
    logic [TIME_W-1:0] stick_last_reg, stick_last_next;
    logic [TIME_W-1:0] switch_last_reg, switch_last_next;
    logic [TIME_W-1:0] mode_last_reg, mode_last_next;

    logic [TIME_W-1:0]   elapsed;
    logic [TIME_W-1:0]   last_sel;
    logic [TIME_W-1:0]   deb_ext;
    logic signed [16:0]  yaw_ext;
    logic signed [16:0]  ythr_pos;
    logic signed [16:0]  ythr_neg;
    logic                thr_low;
    logic                gesture;
    logic                sw_arm;
    logic                sw_disarm;
    logic                armed_mid;

    assign deb_ext  = {{(TIME_W-DEB_W){1'b0}}, cfg.settle_ms};
    assign yaw_ext  = {item.yaw[STICK_W-1], item.yaw};
    assign ythr_pos = $signed({2'b00, cfg.yaw_trip});
    assign ythr_neg = -ythr_pos;

    always_comb begin
        case (item.action)
            ACT_SWITCH: last_sel = switch_last_reg;
            ACT_MODE:   last_sel = mode_last_reg;
            default:    last_sel = stick_last_reg;
        endcase
    end

    // timers wrap modulo 2^32
    assign elapsed = item.now_ms - last_sel;

    assign thr_low   = item.throttle < cfg.throttle_ceiling;
    assign gesture   = armed_reg ? (yaw_ext < ythr_neg) : (yaw_ext > ythr_pos);
    assign sw_arm    = (item.pulse_us > cfg.switch_arm_us) && !armed_reg;
    assign armed_mid = armed_reg | sw_arm;
    assign sw_disarm = (item.pulse_us < cfg.switch_disarm_us) && armed_mid;

    always_comb begin
        armed_next       = armed_reg;
        mode_next        = mode_reg;
        stick_last_next  = stick_last_reg;
        switch_last_next = switch_last_reg;
        mode_last_next   = mode_last_reg;
        unique case (item.action)
            ACT_STICK: begin
                if (thr_low && gesture && (elapsed > deb_ext)) begin
                    armed_next      = !armed_reg;
                    stick_last_next = item.now_ms;
                end
            end
            ACT_SWITCH: begin
                // crossed levels arm then disarm in the same word
                if (elapsed >= deb_ext) begin
                    armed_next = armed_mid & ~sw_disarm;
                    if (sw_arm || sw_disarm) begin
                        switch_last_next = item.now_ms;
                    end
                end
            end
            ACT_MODE: begin
                if (elapsed >= deb_ext) begin
                    mode_last_next = item.now_ms;
                    mode_next      = item.pulse_us > cfg.mode_split_us;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        result.is_armed     = armed_next;
        result.angle_mode   = mode_next;
        result.mode_changed = mode_next ^ mode_reg;
        if (armed_next == armed_reg) begin
            result.arm_change = CHG_NONE;
        end else if (armed_next) begin
            result.arm_change = CHG_ARMED;
        end else begin
            result.arm_change = CHG_DISARMED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg       <= 1'b0;
            mode_reg        <= 1'b0;
            stick_last_reg  <= '0;
            switch_last_reg <= '0;
            mode_last_reg   <= '0;
        end else if (fire) begin
            armed_reg       <= armed_next;
            mode_reg        <= mode_next;
            stick_last_reg  <= stick_last_next;
            switch_last_reg <= switch_last_next;
            mode_last_reg   <= mode_last_next;
        end
    end

endmodule
